>>> hdl/gtg_pkg.sv
// ----------------------------------------------------------------------------
// Go-to-goal package
// Shared widths, the arctangent table and the stage payload type.
// ----------------------------------------------------------------------------
package gtg_pkg;

	localparam int PosW = 18;
	localparam int HdgW = 15;
	localparam int GainW = 16;
	localparam int LinW = 17;
	localparam int AngW = 15;
	localparam int CordW = 34;
	localparam int ZW = 34;
	localparam int TableLen = 24;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 18;

	localparam logic [CfgIdxW-1:0] REG_TARGET_X = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_TARGET_Y = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_GAIN = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_MAX_LINEAR = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_ARRIVE_RADIUS = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_AIM_TOLERANCE = 3'd5;

	localparam logic signed [ZW-1:0] QuarterTurn = 34'sd1073741824;
	localparam logic signed [31:0] GainCompQ30 = 32'sd652032874;
	localparam logic signed [31:0] TwoPiQ28 = 32'sd1686629713;

	typedef struct packed {
		logic signed [CordW-1:0] x;
		logic signed [CordW-1:0] y;
		logic signed [ZW-1:0] z;
		logic signed [HdgW-1:0] hd;
	} cord_t;

	function automatic logic signed [ZW-1:0] atan_turn(input int i);
		logic [31:0] v;
		case (i)
			0: v = 32'h20000000; 1: v = 32'h12E4051E; 2: v = 32'h09FB385B;
			3: v = 32'h051111D4; 4: v = 32'h028B0D43; 5: v = 32'h0145D7E1;
			6: v = 32'h00A2F61E; 7: v = 32'h00517C55; 8: v = 32'h0028BE53;
			9: v = 32'h00145F2F; 10: v = 32'h000A2F98; 11: v = 32'h000517CC;
			12: v = 32'h00028BE6; 13: v = 32'h000145F3; 14: v = 32'h0000A2FA;
			15: v = 32'h0000517D; 16: v = 32'h000028BE; 17: v = 32'h0000145F;
			18: v = 32'h00000A30; 19: v = 32'h00000518; 20: v = 32'h0000028C;
			21: v = 32'h00000146; 22: v = 32'h000000A3; 23: v = 32'h00000051;
			default: v = 32'h0;
		endcase
		return signed'({2'b00, v});
	endfunction

endpackage

>>> hdl/gtg_if.sv
// ----------------------------------------------------------------------------
// Go-to-goal channel interfaces
// Valid/ready channels for the pose input and the velocity command output.
// ----------------------------------------------------------------------------
interface gtg_pose_if;
	logic valid;
	logic ready;
	logic signed [17:0] pos_x;
	logic signed [17:0] pos_y;
	logic signed [14:0] heading;
	modport source (output valid, pos_x, pos_y, heading, input ready);
	modport sink (input valid, pos_x, pos_y, heading, output ready);
endinterface

interface gtg_cmd_if;
	logic valid;
	logic ready;
	logic [16:0] linear_speed;
	logic [14:0] angular_speed;
	modport source (output valid, linear_speed, angular_speed, input ready);
	modport sink (input valid, linear_speed, angular_speed, output ready);
endinterface

>>> hdl/go_to_goal_velocity_command.sv
// A pose beat passes the pre-rotation, CORDIC, decision and output registers in turn.
// Throughput: one pose per cycle; the whole pipeline advances unless the
// output register holds a beat that the sink has not taken.
// Reset clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
// Go-to-goal velocity command
// Pipelined CORDIC vectoring and proportional go-to-goal decision.
// ----------------------------------------------------------------------------
module go_to_goal_velocity_command #(
	parameter int CORDIC_STAGES = 16
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [gtg_pkg::CfgIdxW-1:0] cfg_index,
	input logic [gtg_pkg::CfgDataW-1:0] cfg_data,
	gtg_pose_if.sink pose,
	gtg_cmd_if.source cmd
);
	import gtg_pkg::*;

	logic signed [17:0] target_x_q, target_y_q;
	logic [15:0] gain_q;
	logic [16:0] max_linear_q, arrive_radius_q;
	logic [14:0] aim_tolerance_q;
	logic en, cv, dv;
	cord_t cd;
	logic [16:0] lin;
	logic [14:0] ang;
	logic out_vld_q;
	logic [16:0] lin_q;
	logic [14:0] ang_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_x_q <= 18'sd4096;
			target_y_q <= 18'sd4096;
			gain_q <= 16'd4096;
			max_linear_q <= 17'd12288;
			arrive_radius_q <= 17'd410;
			aim_tolerance_q <= 15'd819;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TARGET_X: target_x_q <= signed'(cfg_data);
				REG_TARGET_Y: target_y_q <= signed'(cfg_data);
				REG_GAIN: gain_q <= cfg_data[15:0];
				REG_MAX_LINEAR: max_linear_q <= cfg_data[16:0];
				REG_ARRIVE_RADIUS: arrive_radius_q <= cfg_data[16:0];
				REG_AIM_TOLERANCE: aim_tolerance_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	assign en = !out_vld_q || cmd.ready;
	assign pose.ready = en;

	gtg_cordic #(.Stages(CORDIC_STAGES)) u_cordic (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(pose.valid),
		.pos_x(pose.pos_x), .pos_y(pose.pos_y), .heading(pose.heading),
		.target_x(target_x_q), .target_y(target_y_q),
		.vld_out(cv), .d_out(cd)
	);

	gtg_decide u_decide (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(cv), .d_in(cd),
		.gain(gain_q), .max_linear(max_linear_q),
		.arrive_radius(arrive_radius_q), .aim_tolerance(aim_tolerance_q),
		.vld_out(dv), .linear_speed(lin), .angular_speed(ang)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= dv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lin_q <= lin;
			ang_q <= ang;
		end
	end

	assign cmd.valid = out_vld_q;
	assign cmd.linear_speed = lin_q;
	assign cmd.angular_speed = ang_q;
endmodule

>>> hdl/gtg_cordic_stage.sv
// ----------------------------------------------------------------------------
// Go-to-goal CORDIC stage
// One registered vectoring iteration with a fixed shift.
// ----------------------------------------------------------------------------
module gtg_cordic_stage #(
	parameter int Shift = 0
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic vld_in,
	input gtg_pkg::cord_t d_in,
	output logic vld_out,
	output gtg_pkg::cord_t d_out
);
	import gtg_pkg::*;

	cord_t nxt;
	logic signed [CordW-1:0] xs, ys;
	logic signed [ZW-1:0] at;

	always_comb begin
		xs = d_in.x >>> Shift;
		ys = d_in.y >>> Shift;
		at = atan_turn(Shift);
		nxt = d_in;
		if (!d_in.y[CordW-1]) begin
			nxt.x = d_in.x + ys;
			nxt.y = d_in.y - xs;
			nxt.z = d_in.z + at;
		end else begin
			nxt.x = d_in.x - ys;
			nxt.y = d_in.y + xs;
			nxt.z = d_in.z - at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= nxt;
		end
	end
endmodule

>>> hdl/gtg_cordic.sv
// ----------------------------------------------------------------------------
// Go-to-goal CORDIC pipeline
// Offset and quadrant pre-rotation, then one register stage per iteration.
// ----------------------------------------------------------------------------
module gtg_cordic #(
	parameter int Stages = 16
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic vld_in,
	input logic signed [17:0] pos_x,
	input logic signed [17:0] pos_y,
	input logic signed [14:0] heading,
	input logic signed [17:0] target_x,
	input logic signed [17:0] target_y,
	output logic vld_out,
	output gtg_pkg::cord_t d_out
);
	import gtg_pkg::*;

	logic vld_s[Stages+1];
	cord_t dat_s[Stages+1];
	cord_t pre;
	logic signed [CordW-1:0] dx, dy;

	always_comb begin
		dx = (CordW'(target_x) - CordW'(pos_x)) <<< 12;
		dy = (CordW'(target_y) - CordW'(pos_y)) <<< 12;
		pre.hd = heading;
		pre.x = dx;
		pre.y = dy;
		pre.z = '0;
		if (dx[CordW-1]) begin
			if (!dy[CordW-1]) begin
				pre.x = dy;
				pre.y = -dx;
				pre.z = QuarterTurn;
			end else begin
				pre.x = -dy;
				pre.y = dx;
				pre.z = -QuarterTurn;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dat_s[0] <= pre;
		end
	end

	for (genvar g = 0; g < Stages; g++) begin : g_it
		gtg_cordic_stage #(.Shift(g)) u_it (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_in(vld_s[g]), .d_in(dat_s[g]),
			.vld_out(vld_s[g+1]), .d_out(dat_s[g+1])
		);
	end

	assign vld_out = vld_s[Stages];
	assign d_out = dat_s[Stages];
endmodule

>>> hdl/gtg_decide.sv
// ----------------------------------------------------------------------------
// Go-to-goal decision pipeline
// Scales distance and bearing, then picks turn, drive or stop.
// ----------------------------------------------------------------------------
module gtg_decide (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic vld_in,
	input gtg_pkg::cord_t d_in,
	input logic [15:0] gain,
	input logic [16:0] max_linear,
	input logic [16:0] arrive_radius,
	input logic [14:0] aim_tolerance,
	output logic vld_out,
	output logic [16:0] linear_speed,
	output logic [14:0] angular_speed
);
	import gtg_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic signed [65:0] dprod_s1, zprod_s1;
	logic signed [HdgW-1:0] hd_s1;
	logic signed [23:0] dist_s2;
	logic [14:0] err_s2;
	logic [22:0] dist_s3;
	logic far_s3, turn_s3;
	logic [14:0] err_s3;
	logic [38:0] lin_s4;
	logic far_s4, turn_s4;
	logic [14:0] err_s4;

	logic signed [65:0] dsh, zsh;
	logic signed [23:0] dist_c;
	logic signed [19:0] bear_c, errv;
	logic [19:0] abse;

	always_comb begin
		dsh = (dprod_s1 + (66'sd1 <<< 41)) >>> 42;
		zsh = (zprod_s1 + (66'sd1 <<< 47)) >>> 48;
		dist_c = dsh[23:0];
		if (dist_c < 0) dist_c = '0;
		bear_c = zsh[19:0];
		errv = bear_c - 20'(hd_s1);
		abse = errv[19] ? 20'(-errv) : 20'(errv);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dprod_s1 <= 66'(d_in.x) * 66'(GainCompQ30);
			zprod_s1 <= 66'(d_in.z) * 66'(TwoPiQ28);
			hd_s1 <= d_in.hd;
			dist_s2 <= dist_c;
			err_s2 <= (abse > 20'd32767) ? 15'h7FFF : abse[14:0];
			dist_s3 <= dist_s2[22:0];
			far_s3 <= dist_s2 > 24'(arrive_radius);
			turn_s3 <= err_s2 > aim_tolerance;
			err_s3 <= err_s2;
			lin_s4 <= ({16'd0, dist_s3} * {23'd0, gain}) >> 12;
			far_s4 <= far_s3;
			turn_s4 <= turn_s3;
			err_s4 <= err_s3;
		end
	end

	always_comb begin
		linear_speed = '0;
		angular_speed = '0;
		if (far_s4) begin
			if (turn_s4) begin
				angular_speed = err_s4;
			end else begin
				linear_speed = (lin_s4 > 39'(max_linear)) ? max_linear : lin_s4[16:0];
			end
		end
	end

	assign vld_out = vld_s4;
endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// Go-to-goal velocity command testbench
// Sends poses through the pose channel under random bursts and gaps, predicts
// each velocity command with a local CORDIC model and compares every beat on
// the command channel in order, across several register settings.
// ----------------------------------------------------------------------------
module tb;
	import gtg_pkg::*;

	localparam int Stages = 16;
	localparam int Latency = Stages + 5;
	localparam longint CycleLimit = 400000;

	typedef struct packed {
		logic [LinW-1:0] lin;
		logic [AngW-1:0] ang;
	} vel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;

	gtg_pose_if pose ();
	gtg_cmd_if cmd ();

	go_to_goal_velocity_command #(.CORDIC_STAGES(Stages)) uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .pose(pose.sink), .cmd(cmd.source)
	);

	longint goal_x, goal_y, k_gain, v_max, r_stop, a_tol;
	vel_t cmd_queue[$];
	int errors = 0;
	longint cycles = 0;
	int stall_mode = 0;

	initial begin
		pose.valid = 1'b0;
		pose.pos_x = '0;
		pose.pos_y = '0;
		pose.heading = '0;
		cmd.ready = 1'b0;
	end

	always #4 clk = ~clk;

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic vel_t predict_cmd(longint px, longint py, longint hd);
		longint x, y, z, t, xs, ys, dst, brg, err;
		vel_t r;
		x = (goal_x - px) * 4096;
		y = (goal_y - py) * 4096;
		z = 0;
		r = '0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; z = 1073741824;
			end else begin
				x = -y; y = t; z = -1073741824;
			end
		end
		for (int i = 0; i < Stages; i++) begin
			xs = floor_shift(x, i);
			ys = floor_shift(y, i);
			if (y >= 0) begin
				x += ys; y -= xs; z += longint'(atan_turn(i));
			end else begin
				x -= ys; y += xs; z -= longint'(atan_turn(i));
			end
		end
		dst = floor_shift(x * 652032874 + (longint'(1) << 41), 42);
		if (dst < 0) dst = 0;
		brg = floor_shift(z * 1686629713 + (longint'(1) << 47), 48);
		err = brg - hd;
		if (err < 0) err = -err;
		if (err > 32767) err = 32767;
		if (dst > r_stop) begin
			if (err > a_tol) r.ang = err[AngW-1:0];
			else begin
				t = (dst * k_gain) >>> 12;
				if (t > v_max) t = v_max;
				r.lin = t[LinW-1:0];
			end
		end
		return r;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) begin
		case (stall_mode)
			0: cmd.ready <= 1'b1;
			1: cmd.ready <= ($urandom_range(0, 3) != 0);
			default: cmd.ready <= ((cycles % 7) < 3);
		endcase
		if (cycles % 600 == 0) stall_mode <= $urandom_range(0, 2);
	end

	always @(posedge clk) begin
		vel_t e;
		if (arst_n && cmd.valid && cmd.ready) begin
			if (cmd_queue.size() == 0) begin
				$display("%0t unexpected command lin=%0d ang=%0d", $time,
					cmd.linear_speed, cmd.angular_speed);
				errors++;
			end else begin
				e = cmd_queue.pop_front();
				if (cmd.linear_speed !== e.lin) begin
					$display("%0t linear_speed expected %0d actual %0d", $time,
						e.lin, cmd.linear_speed);
					errors++;
				end
				if (cmd.angular_speed !== e.ang) begin
					$display("%0t angular_speed expected %0d actual %0d", $time,
						e.ang, cmd.angular_speed);
					errors++;
				end
			end
		end
	end

	task automatic write_reg(logic [CfgIdxW-1:0] idx, longint val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CfgDataW-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_TARGET_X: goal_x = longint'(signed'(val[17:0]));
			REG_TARGET_Y: goal_y = longint'(signed'(val[17:0]));
			REG_GAIN: k_gain = val[15:0];
			REG_MAX_LINEAR: v_max = val[16:0];
			REG_ARRIVE_RADIUS: r_stop = val[16:0];
			REG_AIM_TOLERANCE: a_tol = val[14:0];
			default: ;
		endcase
	endtask

	task automatic send_pose(longint px, longint py, longint hd);
		logic [17:0] bx, by;
		logic [14:0] bh;
		bx = px[17:0];
		by = py[17:0];
		bh = hd[14:0];
		pose.valid <= 1'b1;
		pose.pos_x <= bx;
		pose.pos_y <= by;
		pose.heading <= bh;
		@(posedge clk);
		while (!pose.ready) @(posedge clk);
		cmd_queue.push_back(predict_cmd(longint'(signed'(bx)), longint'(signed'(by)),
			longint'(signed'(bh))));
	endtask

	task automatic pause_pose();
		pose.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		pause_pose();
		while (cmd_queue.size() != 0) @(posedge clk);
		repeat (Latency + 4) @(posedge clk);
	endtask

	task automatic load_setting(longint tx, longint ty, longint g, longint vm,
		longint rs, longint at);
		write_reg(REG_TARGET_X, tx);
		write_reg(REG_TARGET_Y, ty);
		write_reg(REG_GAIN, g);
		write_reg(REG_MAX_LINEAR, vm);
		write_reg(REG_ARRIVE_RADIUS, rs);
		write_reg(REG_AIM_TOLERANCE, at);
	endtask

	task automatic test_directed();
		send_pose(goal_x, goal_y, 0);
		send_pose(-131072, -131072, 0);
		send_pose(131071, 131071, 12868);
		send_pose(-131072, 131071, -12868);
		send_pose(131071, -131072, 16383);
		send_pose(0, 0, -16384);
		send_pose(goal_x - 400, goal_y, 0);
		send_pose(goal_x - 40000, goal_y, 0);
		send_pose(goal_x + 40000, goal_y, 0);
		send_pose(goal_x, goal_y - 40000, 6434);
		send_pose(goal_x, goal_y + 40000, -6434);
		send_pose(goal_x + 40000, goal_y + 1, 12868);
		send_pose(goal_x + 40000, goal_y - 1, -12868);
		drain();
		load_setting(131071, -131072, 65535, 131071, 0, 0);
		send_pose(-131072, 131071, 0);
		send_pose(goal_x, goal_y, 0);
		send_pose(goal_x - 1, goal_y, 0);
		send_pose(goal_x - 1000, goal_y + 3, 0);
		drain();
		load_setting(-131072, 131071, 0, 0, 131071, 32767);
		send_pose(131071, -131072, 0);
		send_pose(0, 0, 0);
		drain();
		write_reg(7, 5);
		write_reg(6, 5);
		send_pose(-200, 300, 100);
		drain();
	endtask

	task automatic send_random(int count, int near_range);
		int burst;
		longint px, py;
		for (int n = 0; n < count; n++) begin
			if (near_range > 0) begin
				px = goal_x + $signed($urandom_range(0, 2 * near_range)) - near_range;
				py = goal_y + $signed($urandom_range(0, 2 * near_range)) - near_range;
			end else begin
				px = $signed($urandom_range(0, 262143)) - 131072;
				py = $signed($urandom_range(0, 262143)) - 131072;
			end
			if (px > 131071) px = 131071;
			if (px < -131072) px = -131072;
			if (py > 131071) py = 131071;
			if (py < -131072) py = -131072;
			if ($urandom_range(0, 9) == 0)
				send_pose(px, py, $signed($urandom_range(0, 32767)) - 16384);
			else send_pose(px, py, $signed($urandom_range(0, 25736)) - 12868);
			if (burst <= 0) begin
				burst = $urandom_range(1, 20);
				if ($urandom_range(0, 2) == 0) begin
					pose.valid <= 1'b0;
					repeat ($urandom_range(1, 6)) @(posedge clk);
				end
			end
			burst--;
		end
	endtask

	task automatic test_random();
		send_random(350, 0);
		send_random(150, 2000);
		drain();
		load_setting($signed($urandom_range(0, 262143)) - 131072,
			$signed($urandom_range(0, 262143)) - 131072, $urandom_range(0, 65535),
			$urandom_range(0, 131071), $urandom_range(0, 4000), $urandom_range(0, 32767));
		send_random(350, 0);
		send_random(150, 5000);
		drain();
		load_setting(-5000, 7000, 9000, 60000, 300, 200);
		send_random(300, 0);
		send_random(200, 800);
		drain();
	endtask

	initial begin
		goal_x = 4096; goal_y = 4096; k_gain = 4096;
		v_max = 12288; r_stop = 410; a_tol = 819;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		if (errors == 0 && cmd_queue.size() == 0) $display("SCOREBOARD CLEAN");
		else $display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
